>>> hw/rtl/scfl_pkg.sv
package scfl_pkg;

  // Default sizing of the block
  localparam int unsigned POOL_BYTES_DEF  = 1048576;
  localparam int unsigned BATCH_DEF       = 64;
  localparam int unsigned NUM_CLASSES_DEF = 8;
  localparam int unsigned STORE_DEPTH_DEF = 65536;

  // Fixed layout of a block and of the address space
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned MAX_CLASSES  = 8;
  localparam int unsigned ADDR_SPACE   = 1048576;
  localparam int unsigned MAX_INDEX    = 65536;

  // Field widths
  localparam int unsigned LIMIT_W  = 21;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned INDEX_W  = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1048576;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOOP      = 2'd1,
    STATUS_TOO_LARGE = 2'd2,
    STATUS_EXHAUSTED = 2'd3
  } status_e;

  // Payload bytes of a class: 16 << class
  function automatic logic [LIMIT_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
    class_bytes = LIMIT_W'(HEADER_BYTES) << cls;
  endfunction

  // Distance between consecutive carved payloads: payload plus header
  function automatic logic [LIMIT_W-1:0] class_stride(input logic [CLASS_W-1:0] cls);
    class_stride = class_bytes(cls) + LIMIT_W'(HEADER_BYTES);
  endfunction

endpackage

>>> hw/rtl/size_class_free_list_allocator.sv
// Size-class free-list allocator.
// Requests enter on the s_axis channel: tuser is the action (0 allocate,
// 1 free), tdata carries the byte count and the payload offset to free.
// One result per request leaves on m_axis: status, granted offset, class
// and the running allocate and free counts.
// The pool limit is written on the cfg channel; the user must write it only
// while the block idles, which the block itself does not enforce. A request
// is taken in the idle state only. At the transfer the link and tag memories
// are read into registered outputs; the execute state then writes back and
// loads the result register. An allocate that finds its list empty carves
// BATCH_BLOCKS blocks, one link and tag write per cycle, paced by the single
// write port of the link memory.
// Reset empties all class lists and clears the pool usage and counters;
// the memories need no clearing pass. If the receiver stalls, the result
// stays in the output register and the block holds before its write-back
// until the register is free; a new request is taken as soon as the
// previous result is loaded.
module size_class_free_list_allocator #(
  parameter int unsigned POOL_BYTES   = scfl_pkg::POOL_BYTES_DEF,
  parameter int unsigned BATCH_BLOCKS = scfl_pkg::BATCH_DEF,
  parameter int unsigned NUM_CLASSES  = scfl_pkg::NUM_CLASSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // request_bytes[20:0], block_address[40:21], zeros
  input  logic [0:0]  s_axis_tuser,  // action[0]
  // Result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // status[1:0], granted_address[21:2],
                                     // class_index[24:22], allocs_done[56:25],
                                     // frees_done[88:57], zeros
  // Pool limit register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [scfl_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import scfl_pkg::*;

  localparam int unsigned DEPTH_RAW = POOL_BYTES / HEADER_BYTES;
  localparam int unsigned DEPTH     = (DEPTH_RAW > MAX_INDEX) ? MAX_INDEX : DEPTH_RAW;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned LIM_CAP   = (POOL_BYTES < ADDR_SPACE) ? POOL_BYTES : ADDR_SPACE;
  localparam int unsigned CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned CNT_W     = (BATCH_BLOCKS > 1) ? $clog2(BATCH_BLOCKS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_CARVE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    OP_NOOP,
    OP_TOO_LARGE,
    OP_POP,
    OP_CARVE,
    OP_FREE
  } op_e;

  // Control state
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] pool_used_q, pool_used_d;
  logic [COUNT_W-1:0] allocs_q, allocs_d;
  logic [COUNT_W-1:0] frees_q, frees_d;
  logic [IDX_W-1:0]   heads_q [NUM_CLASSES];
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Request and carve working registers
  logic [CLASS_W-1:0] cls_q, cls_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [LIMIT_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0]   prev_q, prev_d;

  // Result payload
  logic               out_load;
  logic [STATUS_W-1:0] ostat_q, ostat_d;
  logic [ADDR_W-1:0]  ogrant_q, ogrant_d;
  logic [CLASS_W-1:0] ocls_q, ocls_d;

  // List head update
  logic               heads_we;
  logic [CLS_W-1:0]   heads_wsel;
  logic [IDX_W-1:0]   heads_wdata;

  // Memory ports
  logic               accept;
  logic               link_we, tag_we;
  logic [IDX_W-1:0]   link_waddr, link_wdata, link_rdata, carve_idx;
  logic [CLASS_W-1:0] tag_rdata;

  // Input decode
  logic               in_action;
  logic [LIMIT_W-1:0] in_bytes;
  logic [INDEX_W-1:0] in_idx;
  logic               in_free_ok;
  logic               cls_hit;
  logic [CLASS_W-1:0] cls_in;
  logic [IDX_W-1:0]   head_in;

  // Carve fit check
  logic [LIMIT_W-1:0] stride;
  logic [LIMIT_W:0]   total;
  logic [LIMIT_W-1:0] eff_limit;
  logic               carve_fits;
  logic               slot_free;

  assign in_action = s_axis_tuser[0];
  assign in_bytes  = s_axis_tdata[20:0];
  assign in_idx    = s_axis_tdata[40:25];
  assign in_free_ok = (in_idx != '0) && ({1'b0, in_idx} < (INDEX_W + 1)'(DEPTH));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Find the smallest class that holds the request
  always_comb begin
    cls_hit = 1'b0;
    cls_in  = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (in_bytes <= class_bytes(CLASS_W'(c))) begin
        cls_hit = 1'b1;
        cls_in  = CLASS_W'(c);
      end
    end
  end

  assign head_in = heads_q[cls_in[CLS_W-1:0]];

  // Carve size against the effective pool limit
  assign stride     = class_stride(cls_q);
  assign total      = (LIMIT_W + 1)'(stride * BATCH_BLOCKS);
  assign eff_limit  = (limit_q < LIMIT_W'(LIM_CAP)) ? limit_q : LIMIT_W'(LIM_CAP);
  assign carve_fits = ({1'b0, pool_used_q} + total) <= {1'b0, eff_limit};
  assign carve_idx  = cur_q[IDX_W+3:4];

  // Main sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cls_d       = cls_q;
    addr_d      = addr_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    pool_used_d = pool_used_q;
    allocs_d    = allocs_q;
    frees_d     = frees_q;
    out_load    = 1'b0;
    ostat_d     = ostat_q;
    ogrant_d    = ogrant_q;
    ocls_d      = ocls_q;
    heads_we    = 1'b0;
    heads_wsel  = cls_q[CLS_W-1:0];
    heads_wdata = '0;
    link_we     = 1'b0;
    link_waddr  = carve_idx;
    link_wdata  = prev_q;
    tag_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
          cls_d   = '0;
          addr_d  = head_in;
          if (in_action) begin
            addr_d = in_idx[IDX_W-1:0];
            op_d   = in_free_ok ? OP_FREE : OP_NOOP;
          end else if (in_bytes == '0) begin
            op_d = OP_NOOP;
          end else if (!cls_hit) begin
            op_d = OP_TOO_LARGE;
          end else begin
            cls_d = cls_in;
            op_d  = (head_in != '0) ? OP_POP : OP_CARVE;
          end
        end
      end

      ST_EXEC: begin
        unique case (op_q) inside
          OP_NOOP, OP_TOO_LARGE: begin
            if (slot_free) begin
              out_load = 1'b1;
              ostat_d  = (op_q == OP_NOOP) ? STATUS_NOOP : STATUS_TOO_LARGE;
              ogrant_d = '0;
              ocls_d   = '0;
              state_d  = ST_IDLE;
            end
          end
          OP_POP: begin
            if (slot_free) begin
              heads_we    = 1'b1;
              heads_wdata = link_rdata;
              allocs_d    = allocs_q + 1'b1;
              out_load    = 1'b1;
              ostat_d     = STATUS_OK;
              ogrant_d    = ADDR_W'({addr_q, 4'b0000});
              ocls_d      = cls_q;
              state_d     = ST_IDLE;
            end
          end
          OP_FREE: begin
            if (slot_free) begin
              heads_wsel  = tag_rdata[CLS_W-1:0];
              heads_we    = 1'b1;
              heads_wdata = addr_q;
              link_we     = 1'b1;
              link_waddr  = addr_q;
              link_wdata  = heads_q[tag_rdata[CLS_W-1:0]];
              frees_d     = frees_q + 1'b1;
              out_load    = 1'b1;
              ostat_d     = STATUS_OK;
              ogrant_d    = '0;
              ocls_d      = tag_rdata;
              state_d     = ST_IDLE;
            end
          end
          OP_CARVE: begin
            if (carve_fits) begin
              pool_used_d = pool_used_q + total[LIMIT_W-1:0];
              cur_d       = pool_used_q + LIMIT_W'(HEADER_BYTES);
              prev_d      = '0;
              cnt_d       = '0;
              state_d     = ST_CARVE;
            end else if (slot_free) begin
              out_load = 1'b1;
              ostat_d  = STATUS_EXHAUSTED;
              ogrant_d = '0;
              ocls_d   = cls_q;
              state_d  = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_CARVE: begin
        // Link each new block to the one carved before it
        link_we = 1'b1;
        tag_we  = 1'b1;
        prev_d  = carve_idx;
        cur_d   = cur_q + stride;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(BATCH_BLOCKS - 1)) begin
          heads_we    = 1'b1;
          heads_wdata = prev_q;
          addr_d      = carve_idx;
          state_d     = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (slot_free) begin
          allocs_d = allocs_q + 1'b1;
          out_load = 1'b1;
          ostat_d  = STATUS_OK;
          ogrant_d = ADDR_W'({addr_q, 4'b0000});
          ocls_d   = cls_q;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NOOP;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_RESET;
      pool_used_q <= '0;
      allocs_q    <= '0;
      frees_q     <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      pool_used_q <= pool_used_d;
      allocs_q    <= allocs_d;
      frees_q     <= frees_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // Class list heads, empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads_q[c] <= '0;
      end
    end else if (heads_we) begin
      heads_q[heads_wsel] <= heads_wdata;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    cls_q  <= cls_d;
    addr_q <= addr_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    if (out_load) begin
      ostat_q  <= ostat_d;
      ogrant_q <= ogrant_d;
      ocls_q   <= ocls_d;
    end
  end

  // Next-block links of free blocks
  scfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (accept),
    .raddr_i (head_in),
    .rdata_o (link_rdata)
  );

  // Class tag of each carved block
  scfl_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (carve_idx),
    .wdata_i (cls_q),
    .re_i    (accept),
    .raddr_i (in_idx[IDX_W-1:0]),
    .rdata_o (tag_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, frees_q, allocs_q, ocls_q, ogrant_q, ostat_q};

endmodule

>>> hw/rtl/scfl_ram.sv
module scfl_ram #(
  parameter int unsigned WIDTH = scfl_pkg::INDEX_W,
  parameter int unsigned DEPTH = scfl_pkg::STORE_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  import scfl_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
